@@ src/tkor_pkg.sv @@
// Package for the top-k outlier rejector.
// Holds the fixed field widths, the result kind codes and the cut reset value.
// No dependencies.
`default_nettype none

package tkor_pkg;

  // residual and cut: signed fixed point, 8 fraction bits
  localparam int unsigned RES_W = 20;
  // remaining-hit count as carried in the summary result
  localparam int unsigned REM_W = 9;

  localparam logic signed [RES_W-1:0] RESIDUAL_CUT_RESET = 20'sd256;

  typedef enum logic {
    KIND_REMOVE  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

endpackage : tkor_pkg

`default_nettype wire

@@ src/tkor_list.sv @@
// Sorted outlier list and hit counter for one track chain.
// Inserts a qualifying hit by compare-and-shift in the cycle it is accepted.
// Depends on tkor_pkg.
`default_nettype none

module tkor_list import tkor_pkg::*; #(
  parameter int unsigned LIST_DEPTH     = 4,
  parameter int unsigned MAX_CHAIN_HITS = 256,
  parameter int unsigned HIT_INDEX_BITS = 12,
  localparam int unsigned CNT_W = $clog2(MAX_CHAIN_HITS + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      hit_valid_i,
  input  wire logic [HIT_INDEX_BITS-1:0] hit_id_i,
  input  wire logic signed [RES_W-1:0]   residual_i,
  input  wire logic                      hit_used_i,
  input  wire logic                      chain_end_i,
  input  wire logic signed [RES_W-1:0]   residual_cut_i,
  output logic [HIT_INDEX_BITS-1:0]      ids_o [LIST_DEPTH],
  output logic [LIST_DEPTH-1:0]          vld_o,
  output logic [CNT_W-1:0]               cnt_o
);

  logic [HIT_INDEX_BITS-1:0] ids_q [LIST_DEPTH];
  logic [HIT_INDEX_BITS-1:0] ids_d [LIST_DEPTH];
  logic signed [RES_W-1:0]   res_q [LIST_DEPTH];
  logic signed [RES_W-1:0]   res_d [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     vld_q, vld_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      ins;
  logic [LIST_DEPTH-1:0]     at_or_after;

  assign ins = hit_used_i && (residual_i > residual_cut_i);

  // mark the insertion slot and every slot behind it
  always_comb begin
    logic run;
    run = 1'b0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      run = run | ~vld_q[i] | (residual_i > res_q[i]);
      at_or_after[i] = run;
    end
  end

  always_comb begin
    logic prev;
    int   src;
    prev = 1'b0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      src      = (i == 0) ? 0 : i - 1;
      ids_d[i] = ids_q[i];
      res_d[i] = res_q[i];
      vld_d[i] = vld_q[i];
      if (ins && at_or_after[i]) begin
        if (!prev) begin
          ids_d[i] = hit_id_i;
          res_d[i] = residual_i;
          vld_d[i] = 1'b1;
        end else begin
          ids_d[i] = ids_q[src];
          res_d[i] = res_q[src];
          vld_d[i] = vld_q[src];
        end
      end
      prev = at_or_after[i];
    end
  end

  // saturate the hit count
  assign cnt_d = (cnt_q != CNT_W'(MAX_CHAIN_HITS)) ? cnt_q + CNT_W'(1) : cnt_q;

  assign ids_o = ids_d;
  assign vld_o = vld_d;
  assign cnt_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else if (hit_valid_i) begin
      if (chain_end_i) begin
        vld_q <= '0;
        cnt_q <= '0;
      end else begin
        vld_q <= vld_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit_valid_i) begin
      ids_q <= ids_d;
      res_q <= res_d;
    end
  end

endmodule : tkor_list

`default_nettype wire

@@ src/tkor_drain.sv @@
// Result buffer for a finished chain.
// Holds a snapshot of the list and the remaining count, and emits the
// removal results in list order, then the summary. Depends on tkor_pkg.
`default_nettype none

module tkor_drain import tkor_pkg::*; #(
  parameter int unsigned LIST_DEPTH     = 4,
  parameter int unsigned MAX_CHAIN_HITS = 256,
  parameter int unsigned HIT_INDEX_BITS = 12,
  localparam int unsigned CNT_W = $clog2(MAX_CHAIN_HITS + 1),
  localparam int unsigned DIF_W = (CNT_W > REM_W) ? CNT_W : REM_W
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire logic [HIT_INDEX_BITS-1:0] ids_i [LIST_DEPTH],
  input  wire logic [LIST_DEPTH-1:0]     vld_i,
  input  wire logic [CNT_W-1:0]          cnt_i,
  input  wire logic                      ready_i,
  output logic                           valid_o,
  output kind_e                          kind_o,
  output logic [HIT_INDEX_BITS-1:0]      id_o,
  output logic [REM_W-1:0]               rem_o,
  output logic                           last_o
);

  logic [HIT_INDEX_BITS-1:0] ids_q [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     vld_q;
  logic [REM_W-1:0]          rem_q, rem_d;
  logic                      busy_q;
  logic [LIST_DEPTH-1:0]     first;
  logic [HIT_INDEX_BITS-1:0] sel_id;
  logic [DIF_W-1:0]          pop;

  always_comb begin
    pop = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      pop = pop + DIF_W'(vld_i[i]);
    end
  end

  assign rem_d = REM_W'(DIF_W'(cnt_i) - pop);

  // lowest pending entry and its id
  always_comb begin
    logic seen;
    seen   = 1'b0;
    sel_id = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      first[i] = vld_q[i] & ~seen;
      seen     = seen | vld_q[i];
      sel_id   = sel_id | (ids_q[i] & {HIT_INDEX_BITS{first[i]}});
    end
  end

  assign valid_o = busy_q;
  assign kind_o  = (|vld_q) ? KIND_REMOVE : KIND_SUMMARY;
  assign id_o    = sel_id;
  assign rem_o   = (|vld_q) ? '0 : rem_q;
  assign last_o  = ~(|vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      vld_q  <= vld_i;
    end else if (busy_q && ready_i) begin
      if (|vld_q) begin
        vld_q <= vld_q & ~first;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ids_q <= ids_i;
      rem_q <= rem_d;
    end
  end

endmodule : tkor_drain

`default_nettype wire

@@ src/top_k_outlier_rejector.sv @@
// Top level of the top-k outlier rejector.
// Instantiates tkor_list (sorted list, counter) and tkor_drain (result buffer).
// Depends on tkor_pkg.
//
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: hit_id, residual; tuser: hit_used; tlast: chain_end
// m_axis    out  tdata: removed_hit_id, remaining_hits; tuser: result_kind;
//                tlast: last_result
// cfg       in   data: residual_cut (signed, 8 fraction bits)
//
// Hits follow back to back but for a held chain-end hit. The compare-and-shift
// insertion into the list settles in the cycle of the transfer.
// The chain's last hit snapshots the list into the result buffer, which then
// gives one result a cycle while m_axis_tready_i is high: removals, then the
// summary (up to LIST_DEPTH + 1 results). Mid-chain hits keep flowing while
// that buffer drains; the next chain-end hit waits for the summary's transfer.
// Reset clears the list valid bits, the hit counter and the buffer, and loads
// a cut of 1.0. The cut is written in any cycle; cfg_ready_o is always high.
`default_nettype none

module top_k_outlier_rejector import tkor_pkg::*; #(
  parameter int unsigned LIST_DEPTH     = 4,
  parameter int unsigned MAX_CHAIN_HITS = 256,
  parameter int unsigned HIT_INDEX_BITS = 12,
  localparam int unsigned IN_W  = ((HIT_INDEX_BITS + RES_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((HIT_INDEX_BITS + REM_W + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // hit stream
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [IN_W-1:0]   s_axis_tdata_i,   // hit_id, residual, zero pad
  input  wire logic              s_axis_tuser_i,   // hit_used
  input  wire logic              s_axis_tlast_i,   // chain_end
  // result stream
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [OUT_W-1:0]       m_axis_tdata_o,   // removed_hit_id, remaining_hits, pad
  output logic                   m_axis_tuser_o,   // result_kind
  output logic                   m_axis_tlast_o,   // last_result
  // cut register write
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [RES_W-1:0]  cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_CHAIN_HITS + 1);

  logic signed [RES_W-1:0]   cut_q;
  logic                      hit_xfer;
  logic                      load;
  logic [HIT_INDEX_BITS-1:0] list_ids [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     list_vld;
  logic [CNT_W-1:0]          list_cnt;
  kind_e                     res_kind;
  logic [HIT_INDEX_BITS-1:0] res_id;
  logic [REM_W-1:0]          res_rem;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q <= RESIDUAL_CUT_RESET;
    end else if (cfg_valid_i) begin
      cut_q <= cfg_data_i;
    end
  end

  // hold a chain-end hit while the previous chain's results are pending
  assign s_axis_tready_o = ~m_axis_tvalid_o | ~s_axis_tlast_i;
  assign hit_xfer        = s_axis_tvalid_i & s_axis_tready_o;
  assign load            = hit_xfer & s_axis_tlast_i;

  tkor_list #(
    .LIST_DEPTH     (LIST_DEPTH),
    .MAX_CHAIN_HITS (MAX_CHAIN_HITS),
    .HIT_INDEX_BITS (HIT_INDEX_BITS)
  ) u_list (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hit_valid_i    (hit_xfer),
    .hit_id_i       (s_axis_tdata_i[HIT_INDEX_BITS-1:0]),
    .residual_i     (s_axis_tdata_i[HIT_INDEX_BITS +: RES_W]),
    .hit_used_i     (s_axis_tuser_i),
    .chain_end_i    (s_axis_tlast_i),
    .residual_cut_i (cut_q),
    .ids_o          (list_ids),
    .vld_o          (list_vld),
    .cnt_o          (list_cnt)
  );

  tkor_drain #(
    .LIST_DEPTH     (LIST_DEPTH),
    .MAX_CHAIN_HITS (MAX_CHAIN_HITS),
    .HIT_INDEX_BITS (HIT_INDEX_BITS)
  ) u_drain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .ids_i   (list_ids),
    .vld_i   (list_vld),
    .cnt_i   (list_cnt),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .kind_o  (res_kind),
    .id_o    (res_id),
    .rem_o   (res_rem),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = res_kind;

  // pack the result word, zero pad on top
  generate
    if (OUT_W > HIT_INDEX_BITS + REM_W) begin : g_pad
      assign m_axis_tdata_o = {{(OUT_W - HIT_INDEX_BITS - REM_W){1'b0}}, res_rem, res_id};
    end else begin : g_nopad
      assign m_axis_tdata_o = {res_rem, res_id};
    end
  endgenerate

endmodule : top_k_outlier_rejector

`default_nettype wire
